FILE: rtl/quadrature_amplitude_phase_detector_defines.svh
// Assertion helpers for the quadrature detector.
`ifndef QUADRATURE_AMPLITUDE_PHASE_DETECTOR_DEFINES_SVH
`define QUADRATURE_AMPLITUDE_PHASE_DETECTOR_DEFINES_SVH

// Same-cycle implication, clocked on clk, off during rst.
`define QAPD_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("qapd: same-cycle check failed");

// Next-cycle implication, clocked on clk, off during rst.
`define QAPD_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("qapd: next-cycle check failed");

`endif

FILE: rtl/qapd_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package qapd_pkg;

  localparam int BLOCK_LEN    = 64;
  localparam int SAMPLE_BITS  = 10;
  localparam int SAMPLE_W     = 10;
  localparam int IDX_W        = $clog2(BLOCK_LEN);
  localparam int SUM_W        = SAMPLE_BITS + IDX_W;
  localparam int VEC_W        = SUM_W + 1;
  localparam int RAD_W        = 2 * SUM_W;
  localparam int SER_CNT_W    = $clog2(SUM_W);

  localparam int AMP_W        = 15;
  localparam int AMP_MAX      = (1 << AMP_W) - 1;
  localparam int DEG_W        = 9;
  localparam int REL_W        = 10;

  localparam logic CMD_SAMPLE = 1'b0;
  localparam logic CMD_RECAL  = 1'b1;

  localparam int CORDIC_STEPS = 16;
  localparam int STEP_W       = $clog2(CORDIC_STEPS);
  localparam int CORDIC_FRAC  = 16;
  localparam int CW           = SUM_W + CORDIC_FRAC + 2;
  localparam int ZW           = CORDIC_FRAC + 10;
  localparam int DEG_HALF     = 180;
  localparam int DEG_QUARTER  = 90;

  localparam logic signed [ZW-1:0]    Z_HALF        = ZW'(DEG_HALF << CORDIC_FRAC);
  localparam logic signed [DEG_W-1:0] DEG_HALF_D    = DEG_W'(DEG_HALF);
  localparam logic signed [DEG_W-1:0] DEG_QUARTER_D = DEG_W'(DEG_QUARTER);

  localparam int AMP_KEEP     = 9;
  localparam int AMP_DIV      = 10;
  localparam int PH_KEEP      = 17;
  localparam int PH_NEW       = 3;
  localparam int PH_DIV       = 20;
  localparam int AN_W         = AMP_W + 4;
  localparam int PN_W         = DEG_W + 5;
  localparam int DIV_CNT_W    = $clog2(AN_W);
  localparam int REM_W        = $clog2(PH_DIV);

  // atan(2^-k) in Q16 degrees
  function automatic logic signed [ZW-1:0] atan_q16(input logic [STEP_W-1:0] k);
    unique case (k)
      4'd0:    atan_q16 = ZW'(2949120);
      4'd1:    atan_q16 = ZW'(1740967);
      4'd2:    atan_q16 = ZW'(919879);
      4'd3:    atan_q16 = ZW'(466945);
      4'd4:    atan_q16 = ZW'(234378);
      4'd5:    atan_q16 = ZW'(117305);
      4'd6:    atan_q16 = ZW'(58666);
      4'd7:    atan_q16 = ZW'(29335);
      4'd8:    atan_q16 = ZW'(14668);
      4'd9:    atan_q16 = ZW'(7334);
      4'd10:   atan_q16 = ZW'(3667);
      4'd11:   atan_q16 = ZW'(1833);
      4'd12:   atan_q16 = ZW'(917);
      4'd13:   atan_q16 = ZW'(458);
      4'd14:   atan_q16 = ZW'(229);
      4'd15:   atan_q16 = ZW'(115);
      default: atan_q16 = '0;
    endcase
  endfunction

endpackage

`default_nettype wire

FILE: rtl/qapd_magnitude.sv
`timescale 1ns / 1ps
`default_nettype none

module qapd_magnitude import qapd_pkg::*; (
  input  wire logic                    clk,
  input  wire logic                    rst,
  input  wire logic                    start,
  input  wire logic signed [VEC_W-1:0] re,
  input  wire logic signed [VEC_W-1:0] im,
  output logic                         busy,
  output logic [AMP_W-1:0]             mag
);

  typedef enum logic [1:0] {M_IDLE, M_SQUARE, M_ROOT} mstate_t;

  mstate_t              state;
  logic [SUM_W-1:0]     mcand;
  logic [SUM_W-1:0]     pending;
  logic [RAD_W-1:0]     addend;
  logic [RAD_W-1:0]     acc;
  logic [RAD_W-1:0]     acc_next;
  logic [RAD_W-1:0]     rad;
  logic [SUM_W:0]       rem;
  logic [SUM_W:0]       rem_next;
  logic [SUM_W-1:0]     root;
  logic [SUM_W-1:0]     root_next;
  logic [SUM_W+2:0]     rem_t;
  logic [SUM_W+2:0]     trial;
  logic [SER_CNT_W-1:0] cnt;
  logic                 second;
  logic [SUM_W-1:0]     re_abs;
  logic [SUM_W-1:0]     im_abs;
  logic [AMP_W-1:0]     mag_sat;

  assign re_abs = re[VEC_W-1] ? SUM_W'(-re) : SUM_W'(re);
  assign im_abs = im[VEC_W-1] ? SUM_W'(-im) : SUM_W'(im);

  // shift-add squarer, one multiplier bit per cycle
  assign acc_next = acc + (mcand[0] ? addend : '0);

  // restoring root, one result bit per cycle
  always_comb begin
    rem_t = {rem, rad[RAD_W-1 -: 2]};
    trial = {1'b0, root, 2'b01};
    if (rem_t >= trial) begin
      rem_next  = (SUM_W+1)'(rem_t - trial);
      root_next = {root[SUM_W-2:0], 1'b1};
    end else begin
      rem_next  = (SUM_W+1)'(rem_t);
      root_next = {root[SUM_W-2:0], 1'b0};
    end
    mag_sat = (32'(root_next) > 32'(AMP_MAX)) ? AMP_W'(AMP_MAX) : AMP_W'(root_next);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= M_IDLE;
      busy  <= 1'b0;
    end else begin
      unique case (state)
        M_IDLE: begin
          if (start) begin
            mcand   <= re_abs;
            pending <= im_abs;
            addend  <= RAD_W'(re_abs);
            acc     <= '0;
            cnt     <= '0;
            second  <= 1'b0;
            busy    <= 1'b1;
            state   <= M_SQUARE;
          end
        end
        M_SQUARE: begin
          acc <= acc_next;
          if (cnt == SER_CNT_W'(SUM_W-1)) begin
            cnt <= '0;
            if (!second) begin
              second <= 1'b1;
              mcand  <= pending;
              addend <= RAD_W'(pending);
            end else begin
              rad   <= acc_next;
              rem   <= '0;
              root  <= '0;
              state <= M_ROOT;
            end
          end else begin
            mcand  <= mcand >> 1;
            addend <= addend << 1;
            cnt    <= cnt + 1'b1;
          end
        end
        M_ROOT: begin
          rad  <= rad << 2;
          rem  <= rem_next;
          root <= root_next;
          cnt  <= cnt + 1'b1;
          if (cnt == SER_CNT_W'(SUM_W-1)) begin
            mag   <= mag_sat;
            busy  <= 1'b0;
            state <= M_IDLE;
          end
        end
        default: state <= M_IDLE;
      endcase
    end
  end

endmodule

`default_nettype wire

FILE: rtl/qapd_cordic.sv
`timescale 1ns / 1ps
`default_nettype none

module qapd_cordic import qapd_pkg::*; (
  input  wire logic                    clk,
  input  wire logic                    rst,
  input  wire logic                    start,
  input  wire logic signed [VEC_W-1:0] re,
  input  wire logic signed [VEC_W-1:0] im,
  output logic                         busy,
  output logic signed [DEG_W-1:0]      deg
);

  typedef enum logic {C_IDLE, C_RUN} cstate_t;

  cstate_t                  state;
  logic signed [CW-1:0]     x;
  logic signed [CW-1:0]     y;
  logic signed [ZW-1:0]     z;
  logic signed [CW-1:0]     xs;
  logic signed [CW-1:0]     ys;
  logic signed [CW-1:0]     x_next;
  logic signed [CW-1:0]     y_next;
  logic signed [ZW-1:0]     z_next;
  logic signed [ZW-1:0]     z_trunc;
  logic signed [VEC_W-1:0]  x_c;
  logic signed [VEC_W-1:0]  y_c;
  logic signed [CW-1:0]     x_init;
  logic signed [CW-1:0]     y_init;
  logic signed [ZW-1:0]     z_init;
  logic [STEP_W-1:0]        k;

  // left half plane: flip the vector, start from +/-180
  always_comb begin
    x_c    = re[VEC_W-1] ? -re : re;
    y_c    = re[VEC_W-1] ? -im : im;
    x_init = CW'(x_c) <<< CORDIC_FRAC;
    y_init = CW'(y_c) <<< CORDIC_FRAC;
    if (!re[VEC_W-1]) begin
      z_init = '0;
    end else if (im[VEC_W-1]) begin
      z_init = -Z_HALF;
    end else begin
      z_init = Z_HALF;
    end
  end

  always_comb begin
    xs = x >>> k;
    ys = y >>> k;
    if (!y[CW-1]) begin
      x_next = x + ys;
      y_next = y - xs;
      z_next = z + atan_q16(k);
    end else begin
      x_next = x - ys;
      y_next = y + xs;
      z_next = z - atan_q16(k);
    end
    z_trunc = z_next[ZW-1] ? -((-z_next) >>> CORDIC_FRAC) : (z_next >>> CORDIC_FRAC);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= C_IDLE;
      busy  <= 1'b0;
    end else begin
      unique case (state)
        C_IDLE: begin
          if (start) begin
            if (re == '0 && im == '0) begin
              deg <= '0;
            end else if (im == '0) begin
              deg <= re[VEC_W-1] ? DEG_HALF_D : '0;
            end else if (re == '0) begin
              deg <= im[VEC_W-1] ? -DEG_QUARTER_D : DEG_QUARTER_D;
            end else begin
              x     <= x_init;
              y     <= y_init;
              z     <= z_init;
              k     <= '0;
              busy  <= 1'b1;
              state <= C_RUN;
            end
          end
        end
        C_RUN: begin
          x <= x_next;
          y <= y_next;
          z <= z_next;
          k <= k + 1'b1;
          if (k == STEP_W'(CORDIC_STEPS-1)) begin
            deg   <= DEG_W'(z_trunc);
            busy  <= 1'b0;
            state <= C_IDLE;
          end
        end
        default: state <= C_IDLE;
      endcase
    end
  end

endmodule

`default_nettype wire

FILE: rtl/qapd_smooth.sv
`timescale 1ns / 1ps
`default_nettype none

module qapd_smooth import qapd_pkg::*; (
  input  wire logic                    clk,
  input  wire logic                    rst,
  input  wire logic                    start,
  input  wire logic [AMP_W-1:0]        amp_cur,
  input  wire logic signed [DEG_W-1:0] ph_cur,
  input  wire logic [AMP_W-1:0]        mag,
  input  wire logic signed [DEG_W-1:0] deg,
  output logic                         busy,
  output logic [AMP_W-1:0]             amp_new,
  output logic signed [DEG_W-1:0]      ph_new
);

  typedef enum logic {S_IDLE, S_RUN} sstate_t;

  sstate_t                 state;
  logic [AN_W-1:0]         an;
  logic [AN_W-1:0]         pm;
  logic                    neg;
  logic [REM_W-1:0]        ra;
  logic [REM_W-1:0]        rp;
  logic [REM_W:0]          ra_t;
  logic [REM_W:0]          rp_t;
  logic [REM_W-1:0]        ra_next;
  logic [REM_W-1:0]        rp_next;
  logic                    qa;
  logic                    qp;
  logic [DIV_CNT_W-1:0]    cnt;
  logic [AN_W-1:0]         an_init;
  logic signed [PN_W-1:0]  pn;
  logic [AN_W-1:0]         pm_init;

  always_comb begin
    an_init = AN_W'(amp_cur) * AN_W'(AMP_KEEP) + AN_W'(mag);
    pn      = PN_W'(ph_cur) * PN_W'(PH_KEEP) + PN_W'(deg) * PN_W'(PH_NEW);
    pm_init = AN_W'(pn[PN_W-1] ? -pn : pn);
  end

  // restoring divide by constant, quotient bits shift in at the bottom
  always_comb begin
    ra_t = {ra, an[AN_W-1]};
    rp_t = {rp, pm[AN_W-1]};
    qa   = (ra_t >= (REM_W+1)'(AMP_DIV));
    qp   = (rp_t >= (REM_W+1)'(PH_DIV));
    ra_next = qa ? REM_W'(ra_t - (REM_W+1)'(AMP_DIV)) : REM_W'(ra_t);
    rp_next = qp ? REM_W'(rp_t - (REM_W+1)'(PH_DIV)) : REM_W'(rp_t);
  end

  assign amp_new = AMP_W'(an);
  assign ph_new  = DEG_W'(neg ? -pm : pm);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      busy  <= 1'b0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (start) begin
            an    <= an_init;
            pm    <= pm_init;
            neg   <= pn[PN_W-1];
            ra    <= '0;
            rp    <= '0;
            cnt   <= '0;
            busy  <= 1'b1;
            state <= S_RUN;
          end
        end
        S_RUN: begin
          an  <= {an[AN_W-2:0], qa};
          pm  <= {pm[AN_W-2:0], qp};
          ra  <= ra_next;
          rp  <= rp_next;
          cnt <= cnt + 1'b1;
          if (cnt == DIV_CNT_W'(AN_W-1)) begin
            busy  <= 1'b0;
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

`default_nettype wire

FILE: rtl/quadrature_amplitude_phase_detector.sv
// Quadrature amplitude and phase detector. ADC samples taken at four times the carrier
// rate are folded into I/Q sums; each block of 64 samples ends in one result with the
// smoothed amplitude, smoothed phase, the calibration offset and phase minus offset.
// A recalibrate item latches the smoothed phase as offset and returns a result too.
// A sample that does not end a block leaves the input unstalled. The sample that ends a
// block stalls the input while a bit-serial squarer (two passes) and a restoring root
// run, with the 16-step CORDIC beside them, then through the bit-serial division for
// the smoothing and the load of the result register. A recalibrate stalls the input
// until its result is loaded into the result register. The input also waits while a
// new result cannot enter the result register because the previous one is stalled.
`timescale 1ns / 1ps
`default_nettype none
`include "quadrature_amplitude_phase_detector_defines.svh"

module quadrature_amplitude_phase_detector import qapd_pkg::*; (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 item_valid,
  output logic                      item_stall,
  input  wire logic                 command,
  input  wire logic [SAMPLE_W-1:0]  sample,
  output logic                      result_valid,
  input  wire logic                 result_stall,
  output logic [AMP_W-1:0]          amplitude,
  output logic signed [DEG_W-1:0]   phase_deg,
  output logic signed [REL_W-1:0]   relative_phase_deg,
  output logic signed [DEG_W-1:0]   offset_deg
);

  typedef enum logic [1:0] {T_IDLE, T_CALC, T_SMOOTH, T_DONE} tstate_t;

  localparam logic [1:0] POS_RE_ADD = 2'd0;
  localparam logic [1:0] POS_IM_ADD = 2'd1;
  localparam logic [1:0] POS_RE_SUB = 2'd2;

  tstate_t                  state;
  logic [IDX_W-1:0]         idx;
  logic signed [SUM_W-1:0]  real_sum;
  logic signed [SUM_W-1:0]  imag_sum;
  logic signed [SUM_W-1:0]  real_next;
  logic signed [SUM_W-1:0]  imag_next;
  logic signed [SUM_W-1:0]  s_ext;
  logic signed [VEC_W-1:0]  vec_re;
  logic signed [VEC_W-1:0]  vec_im;
  logic [AMP_W-1:0]         amp_s;
  logic signed [DEG_W-1:0]  ph_s;
  logic signed [DEG_W-1:0]  offset;
  logic                     accept;
  logic                     block_end;
  logic                     smooth_start;
  logic                     mag_busy;
  logic                     cor_busy;
  logic                     smooth_busy;
  logic [AMP_W-1:0]         mag;
  logic signed [DEG_W-1:0]  deg;
  logic [AMP_W-1:0]         amp_new;
  logic signed [DEG_W-1:0]  ph_new;

  assign item_stall   = (state != T_IDLE);
  assign accept       = item_valid && !item_stall;
  assign block_end    = accept && (command == CMD_SAMPLE) && (idx == IDX_W'(BLOCK_LEN-1));
  assign smooth_start = (state == T_CALC) && !mag_busy && !cor_busy;

  always_comb begin
    s_ext     = SUM_W'(sample[SAMPLE_BITS-1:0]);
    real_next = real_sum;
    imag_next = imag_sum;
    case (idx[1:0])
      POS_RE_ADD: real_next = real_sum + s_ext;
      POS_IM_ADD: imag_next = imag_sum + s_ext;
      POS_RE_SUB: real_next = real_sum - s_ext;
      default:    imag_next = imag_sum - s_ext;
    endcase
    vec_re = VEC_W'(real_next);
    vec_im = -VEC_W'(imag_next);
  end

  qapd_magnitude u_mag (
    .clk   (clk),
    .rst   (rst),
    .start (block_end),
    .re    (vec_re),
    .im    (vec_im),
    .busy  (mag_busy),
    .mag   (mag)
  );

  qapd_cordic u_cordic (
    .clk   (clk),
    .rst   (rst),
    .start (block_end),
    .re    (vec_re),
    .im    (vec_im),
    .busy  (cor_busy),
    .deg   (deg)
  );

  qapd_smooth u_smooth (
    .clk     (clk),
    .rst     (rst),
    .start   (smooth_start),
    .amp_cur (amp_s),
    .ph_cur  (ph_s),
    .mag     (mag),
    .deg     (deg),
    .busy    (smooth_busy),
    .amp_new (amp_new),
    .ph_new  (ph_new)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= T_IDLE;
      idx          <= '0;
      real_sum     <= '0;
      imag_sum     <= '0;
      amp_s        <= '0;
      ph_s         <= '0;
      offset       <= '0;
      result_valid <= 1'b0;
    end else begin
      if (result_valid && !result_stall && state != T_DONE) begin
        result_valid <= 1'b0;
      end
      unique case (state)
        T_IDLE: begin
          if (accept) begin
            if (command == CMD_RECAL) begin
              offset <= ph_s;
              state  <= T_DONE;
            end else if (block_end) begin
              idx      <= '0;
              real_sum <= '0;
              imag_sum <= '0;
              state    <= T_CALC;
            end else begin
              idx      <= idx + 1'b1;
              real_sum <= real_next;
              imag_sum <= imag_next;
            end
          end
        end
        T_CALC: begin
          if (smooth_start) begin
            state <= T_SMOOTH;
          end
        end
        T_SMOOTH: begin
          if (!smooth_busy) begin
            amp_s <= amp_new;
            ph_s  <= ph_new;
            state <= T_DONE;
          end
        end
        T_DONE: begin
          if (!result_valid || !result_stall) begin
            result_valid       <= 1'b1;
            amplitude          <= amp_s;
            phase_deg          <= ph_s;
            relative_phase_deg <= REL_W'(ph_s) - REL_W'(offset);
            offset_deg         <= offset;
            state              <= T_IDLE;
          end
        end
        default: state <= T_IDLE;
      endcase
    end
  end

  `QAPD_ASSERT_SAME(a_sums_clear_at_block_start, idx == '0, real_sum == '0 && imag_sum == '0)
  `QAPD_ASSERT_NEXT(a_block_end_starts_root, block_end, mag_busy && state == T_CALC)
  `QAPD_ASSERT_NEXT(a_recal_latches_phase, accept && command == CMD_RECAL, offset == $past(ph_s))
  `QAPD_ASSERT_NEXT(a_recal_goes_done, accept && command == CMD_RECAL, state == T_DONE)
  `QAPD_ASSERT_SAME(a_no_accept_while_busy, mag_busy || cor_busy || smooth_busy, item_stall)

endmodule

`default_nettype wire
